// File: rtl/rhnc_pkg.sv
// shared types, widths and codes of the rgb extreme-bin noise classifier
// no dependencies; imported by every module of the block
package rhnc_pkg;

	// accumulator widths
	localparam int CNT_W      = 32;
	localparam int SUM_W      = CNT_W + 8;
	localparam int PERMILLE_W = 10;
	localparam int BOUND_W    = 8;
	localparam int SAMPLE_W   = 8;
	localparam int PROD_W     = CNT_W + PERMILLE_W;
	localparam int ALL_W      = SUM_W + 2;
	localparam int NCH        = 3;

	localparam logic [PERMILLE_W-1:0] PERMILLE_SCALE = PERMILLE_W'(1000);
	localparam logic [SAMPLE_W-1:0]   SAMPLE_MIN     = '0;
	localparam logic [SAMPLE_W-1:0]   SAMPLE_MAX     = '1;
	localparam logic [CNT_W-1:0]      CNT_MAX        = '1;
	localparam logic [SUM_W-1:0]      SUM_MAX        = '1;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_WEAK   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STRONG = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH   = 2'd3;

	// verdict codes
	localparam logic [1:0] VERDICT_NONE   = 2'd0;
	localparam logic [1:0] VERDICT_STRONG = 2'd1;
	localparam logic [1:0] VERDICT_WEAK   = 2'd2;

	typedef struct packed {
		logic [PERMILLE_W-1:0] weak_pm;
		logic [PERMILLE_W-1:0] strong_pm;
		logic [BOUND_W-1:0]    low;
		logic [BOUND_W-1:0]    high;
	} cfg_t;

	// accumulator snapshot taken at the end of a sequence
	typedef struct packed {
		logic [NCH-1:0][CNT_W-1:0] dark;
		logic [NCH-1:0][CNT_W-1:0] bright;
		logic [NCH-1:0][SUM_W-1:0] sums;
		logic [CNT_W-1:0]          total;
		logic                      sat;
	} snap_t;

	// scaled values ready for comparison
	typedef struct packed {
		logic [NCH-1:0][PROD_W-1:0] dark_k;
		logic [NCH-1:0][PROD_W-1:0] bright_k;
		logic [PROD_W-1:0]          weak_lim;
		logic [PROD_W-1:0]          strong_lim;
		logic [NCH-1:0][SUM_W-1:0]  sums;
		logic [ALL_W-1:0]           all;
		logic [SUM_W-1:0]           lo_lim;
		logic [SUM_W-1:0]           hi_lim;
		logic [PROD_W-1:0]          lo3_lim;
		logic [PROD_W-1:0]          hi3_lim;
		logic                       sat;
	} prod_t;

endpackage

// File: rtl/rhnc_accum.sv
// input register, saturating per-channel accumulators and end-of-sequence snapshot
// depends on rhnc_pkg
module rhnc_accum (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            blue_value,
	input  logic [7:0]            green_value,
	input  logic [7:0]            red_value,
	input  logic                  sequence_end,
	output logic                  snap_valid,
	input  logic                  snap_ready,
	output rhnc_pkg::snap_t       snap
);
	import rhnc_pkg::*;

	logic                         valid_s1;
	logic [NCH-1:0][SAMPLE_W-1:0] px_s1;
	logic                         seq_end_s1;

	logic [NCH-1:0][CNT_W-1:0] dark_q;
	logic [NCH-1:0][CNT_W-1:0] bright_q;
	logic [NCH-1:0][SUM_W-1:0] sums_q;
	logic [CNT_W-1:0]          total_q;
	logic                      sat_q;

	snap_t snap_s2;
	logic  snap_valid_s2;

	snap_t nxt;
	logic  snap_free;
	logic  s1_move;
	logic  dark_hit;
	logic  bright_hit;
	logic  [SUM_W:0] sum_ext;

	// handshake: an end request needs room in the snapshot stage
	assign snap_free = !snap_valid_s2 || snap_ready;
	assign s1_move   = valid_s1 && (!seq_end_s1 || snap_free);
	assign in_ready  = !valid_s1 || s1_move;

	// saturating accumulator update for the request in stage 1
	always_comb begin
		nxt     = '0;
		nxt.sat = sat_q;
		dark_hit   = 1'b0;
		bright_hit = 1'b0;
		sum_ext    = '0;
		for (int c = 0; c < NCH; c++) begin
			dark_hit   = (px_s1[c] == SAMPLE_MIN);
			bright_hit = (px_s1[c] == SAMPLE_MAX);
			nxt.dark[c]   = dark_q[c];
			nxt.bright[c] = bright_q[c];
			if (dark_hit) begin
				if (dark_q[c] == CNT_MAX) nxt.sat = 1'b1;
				else nxt.dark[c] = dark_q[c] + CNT_W'(1);
			end
			if (bright_hit) begin
				if (bright_q[c] == CNT_MAX) nxt.sat = 1'b1;
				else nxt.bright[c] = bright_q[c] + CNT_W'(1);
			end
			sum_ext = {1'b0, sums_q[c]} + (SUM_W + 1)'(px_s1[c]);
			if (sum_ext[SUM_W]) begin
				nxt.sums[c] = SUM_MAX;
				nxt.sat     = 1'b1;
			end else begin
				nxt.sums[c] = sum_ext[SUM_W-1:0];
			end
		end
		if (total_q == CNT_MAX) begin
			nxt.total = CNT_MAX;
			nxt.sat   = 1'b1;
		end else begin
			nxt.total = total_q + CNT_W'(1);
		end
	end

	// stage 1 input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			px_s1[0]   <= blue_value;
			px_s1[1]   <= green_value;
			px_s1[2]   <= red_value;
			seq_end_s1 <= sequence_end;
		end
	end

	// accumulators, cleared after the last pixel of a sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_q   <= '0;
			bright_q <= '0;
			sums_q   <= '0;
			total_q  <= '0;
			sat_q    <= 1'b0;
		end else if (s1_move) begin
			if (seq_end_s1) begin
				dark_q   <= '0;
				bright_q <= '0;
				sums_q   <= '0;
				total_q  <= '0;
				sat_q    <= 1'b0;
			end else begin
				dark_q   <= nxt.dark;
				bright_q <= nxt.bright;
				sums_q   <= nxt.sums;
				total_q  <= nxt.total;
				sat_q    <= nxt.sat;
			end
		end
	end

	// stage 2 snapshot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s2 <= 1'b0;
		end else if (snap_free) begin
			snap_valid_s2 <= s1_move && seq_end_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && seq_end_s1) begin
			snap_s2 <= nxt;
		end
	end

	assign snap_valid = snap_valid_s2;
	assign snap       = snap_s2;

endmodule

// File: rtl/rhnc_scale.sv
// scaling stage: cross-multiplies counts and sums against thresholds and bounds
// depends on rhnc_pkg
module rhnc_scale (
	input  logic             clk,
	input  logic             arst_n,
	input  rhnc_pkg::cfg_t   cfg,
	input  logic             snap_valid,
	output logic             snap_ready,
	input  rhnc_pkg::snap_t  snap,
	output logic             prod_valid,
	input  logic             prod_ready,
	output rhnc_pkg::prod_t  prod
);
	import rhnc_pkg::*;

	prod_t prod_s3;
	logic  valid_s3;
	prod_t nxt;
	logic  [PERMILLE_W-1:0] low3;
	logic  [PERMILLE_W-1:0] high3;

	assign snap_ready = !valid_s3 || prod_ready;

	// three times the mean bounds, shift and add
	assign low3  = {2'b00, cfg.low}  + {1'b0, cfg.low, 1'b0};
	assign high3 = {2'b00, cfg.high} + {1'b0, cfg.high, 1'b0};

	// products and channel total
	always_comb begin
		nxt = '0;
		for (int c = 0; c < NCH; c++) begin
			nxt.dark_k[c]   = {{PERMILLE_W{1'b0}}, snap.dark[c]}
				* {{CNT_W{1'b0}}, PERMILLE_SCALE};
			nxt.bright_k[c] = {{PERMILLE_W{1'b0}}, snap.bright[c]}
				* {{CNT_W{1'b0}}, PERMILLE_SCALE};
		end
		nxt.weak_lim   = {{CNT_W{1'b0}}, cfg.weak_pm} * {{PERMILLE_W{1'b0}}, snap.total};
		nxt.strong_lim = {{CNT_W{1'b0}}, cfg.strong_pm} * {{PERMILLE_W{1'b0}}, snap.total};
		nxt.lo_lim     = {{CNT_W{1'b0}}, cfg.low} * {{BOUND_W{1'b0}}, snap.total};
		nxt.hi_lim     = {{CNT_W{1'b0}}, cfg.high} * {{BOUND_W{1'b0}}, snap.total};
		nxt.lo3_lim    = {{CNT_W{1'b0}}, low3} * {{PERMILLE_W{1'b0}}, snap.total};
		nxt.hi3_lim    = {{CNT_W{1'b0}}, high3} * {{PERMILLE_W{1'b0}}, snap.total};
		nxt.sums       = snap.sums;
		nxt.all        = ALL_W'(snap.sums[0]) + ALL_W'(snap.sums[1]) + ALL_W'(snap.sums[2]);
		nxt.sat        = snap.sat;
	end

	// stage 3 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (snap_ready) begin
			valid_s3 <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_valid && snap_ready) begin
			prod_s3 <= nxt;
		end
	end

	assign prod_valid = valid_s3;
	assign prod       = prod_s3;

endmodule

// File: rtl/rhnc_decide.sv
// verdict stage: compares scaled values and holds the result register
// depends on rhnc_pkg
module rhnc_decide (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             prod_valid,
	output logic             prod_ready,
	input  rhnc_pkg::prod_t  prod,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       noise_verdict,
	output logic             count_overflow
);
	import rhnc_pkg::*;

	logic       out_valid_q;
	logic [1:0] verdict_q;
	logic       overflow_q;

	logic       weak_ok;
	logic       strong_ok;
	logic       means_ok;
	logic [1:0] verdict;

	assign prod_ready = !out_valid_q || out_ready;

	// strict comparisons on every channel
	always_comb begin
		weak_ok   = 1'b1;
		strong_ok = 1'b1;
		means_ok  = (prod.all > ALL_W'(prod.lo3_lim)) && (prod.all < ALL_W'(prod.hi3_lim));
		for (int c = 0; c < NCH; c++) begin
			if (!(prod.dark_k[c] > prod.weak_lim) || !(prod.bright_k[c] > prod.weak_lim))
				weak_ok = 1'b0;
			if (!(prod.dark_k[c] > prod.strong_lim) || !(prod.bright_k[c] > prod.strong_lim))
				strong_ok = 1'b0;
			if (!(prod.sums[c] > prod.lo_lim) || !(prod.sums[c] < prod.hi_lim))
				means_ok = 1'b0;
		end
		if (weak_ok && means_ok) verdict = strong_ok ? VERDICT_STRONG : VERDICT_WEAK;
		else verdict = VERDICT_NONE;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (prod_ready) begin
			out_valid_q <= prod_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (prod_valid && prod_ready) begin
			verdict_q  <= verdict;
			overflow_q <= prod.sat;
		end
	end

	assign out_valid      = out_valid_q;
	assign noise_verdict  = verdict_q;
	assign count_overflow = overflow_q;

endmodule

// File: rtl/rgb_histogram_noise_classifier.sv
// top level of the rgb extreme-bin noise classifier: configuration registers and stages
// depends on rhnc_pkg, rhnc_accum, rhnc_scale, rhnc_decide
//
//   channel  handshake            payload
//   in       in_valid/in_ready    blue_value, green_value, red_value, sequence_end
//   out      out_valid/out_ready  noise_verdict, count_overflow
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one pixel request is taken every clock unless stalled; accumulators update from stage 1
// from its end-of-sequence pixel a verdict passes the snapshot, stage 3 and result registers
// the three verdict stages are elastic: a waiting result stalls input only when all are full
// cfg_ready is always high; reset restores the default thresholds and clears all counts
module rgb_histogram_noise_classifier (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] blue_value,
	input  logic [7:0] green_value,
	input  logic [7:0] red_value,
	input  logic       sequence_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] noise_verdict,
	output logic       count_overflow,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data
);
	import rhnc_pkg::*;

	cfg_t  cfg_q;
	logic  snap_valid;
	logic  snap_ready;
	snap_t snap;
	logic  prod_valid;
	logic  prod_ready;
	prod_t prod;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.weak_pm   <= PERMILLE_W'(10);
			cfg_q.strong_pm <= PERMILLE_W'(35);
			cfg_q.low       <= BOUND_W'(108);
			cfg_q.high      <= BOUND_W'(148);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WEAK:   cfg_q.weak_pm   <= cfg_data;
				CFG_STRONG: cfg_q.strong_pm <= cfg_data;
				CFG_LOW:    cfg_q.low       <= cfg_data[BOUND_W-1:0];
				CFG_HIGH:   cfg_q.high      <= cfg_data[BOUND_W-1:0];
				default: begin
				end
			endcase
		end
	end

	rhnc_accum u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.blue_value   (blue_value),
		.green_value  (green_value),
		.red_value    (red_value),
		.sequence_end (sequence_end),
		.snap_valid   (snap_valid),
		.snap_ready   (snap_ready),
		.snap         (snap)
	);

	rhnc_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap),
		.prod_valid (prod_valid),
		.prod_ready (prod_ready),
		.prod       (prod)
	);

	rhnc_decide u_decide (
		.clk            (clk),
		.arst_n         (arst_n),
		.prod_valid     (prod_valid),
		.prod_ready     (prod_ready),
		.prod           (prod),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.noise_verdict  (noise_verdict),
		.count_overflow (count_overflow)
	);

endmodule

// File: test/rhnc_verdict_checker.sv
// verdict checker for the rgb extreme-bin noise classifier: watches the pixel,
// verdict and register channels, keeps its own accumulators and thresholds
// depends on rhnc_pkg
module rhnc_verdict_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [rhnc_pkg::SAMPLE_W-1:0]   blue_value,
	input  logic [rhnc_pkg::SAMPLE_W-1:0]   green_value,
	input  logic [rhnc_pkg::SAMPLE_W-1:0]   red_value,
	input  logic                            sequence_end,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [1:0]                      noise_verdict,
	input  logic                            count_overflow,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [rhnc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rhnc_pkg::PERMILLE_W-1:0] cfg_data,
	output int                              errors,
	output int                              pending,
	output int                              verdicts_checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import rhnc_pkg::*;

	// thresholds after reset
	localparam logic [PERMILLE_W-1:0] WEAK_DEFAULT   = 10'd10;
	localparam logic [PERMILLE_W-1:0] STRONG_DEFAULT = 10'd35;
	localparam logic [BOUND_W-1:0]    LOW_DEFAULT    = 8'd108;
	localparam logic [BOUND_W-1:0]    HIGH_DEFAULT   = 8'd148;

	typedef struct packed {
		logic [1:0] verdict;
		logic       overflow;
	} verdict_rec_t;

	logic [CNT_W-1:0] dark_n   [NCH];
	logic [CNT_W-1:0] bright_n [NCH];
	logic [SUM_W-1:0] level_sum[NCH];
	logic [CNT_W-1:0] pixels_n;
	logic             clipped;
	cfg_t             thresholds;
	verdict_rec_t     verdicts_due[$];
	int               error_cnt;
	int               checked_cnt;

	function automatic void clear_sequence();
		int c;
		for (c = 0; c < NCH; c++) begin
			dark_n[c]    = '0;
			bright_n[c]  = '0;
			level_sum[c] = '0;
		end
		pixels_n = '0;
		clipped  = 1'b0;
	endfunction

	// one pixel into the accumulators; a full counter holds and marks saturation
	function automatic void fold_pixel(input logic [NCH-1:0][SAMPLE_W-1:0] px);
		int c;
		for (c = 0; c < NCH; c++) begin
			if (px[c] == SAMPLE_MIN) begin
				if (dark_n[c] == CNT_MAX) clipped = 1'b1;
				else dark_n[c] = dark_n[c] + 1'b1;
			end
			if (px[c] == SAMPLE_MAX) begin
				if (bright_n[c] == CNT_MAX) clipped = 1'b1;
				else bright_n[c] = bright_n[c] + 1'b1;
			end
			if (SUM_MAX - level_sum[c] < SUM_W'(px[c])) begin
				clipped      = 1'b1;
				level_sum[c] = SUM_MAX;
			end else begin
				level_sum[c] = level_sum[c] + SUM_W'(px[c]);
			end
		end
		if (pixels_n == CNT_MAX) clipped = 1'b1;
		else pixels_n = pixels_n + 1'b1;
	endfunction

	// fractions and means as cross-multiplications, all comparisons strict
	function automatic logic [1:0] judge_sequence();
		logic [63:0] weak_lim, strong_lim, lo_lim, hi_lim;
		logic [63:0] dark_k, bright_k, level, all_sum;
		logic        weak_ok, strong_ok, mean_ok;
		int          c;
		weak_lim   = 64'(thresholds.weak_pm) * 64'(pixels_n);
		strong_lim = 64'(thresholds.strong_pm) * 64'(pixels_n);
		lo_lim     = 64'(thresholds.low) * 64'(pixels_n);
		hi_lim     = 64'(thresholds.high) * 64'(pixels_n);
		weak_ok    = 1'b1;
		strong_ok  = 1'b1;
		mean_ok    = 1'b1;
		all_sum    = '0;
		for (c = 0; c < NCH; c++) begin
			dark_k   = 64'(dark_n[c]) * 64'(PERMILLE_SCALE);
			bright_k = 64'(bright_n[c]) * 64'(PERMILLE_SCALE);
			level    = 64'(level_sum[c]);
			if (dark_k <= weak_lim || bright_k <= weak_lim) weak_ok = 1'b0;
			if (dark_k <= strong_lim || bright_k <= strong_lim) strong_ok = 1'b0;
			if (level <= lo_lim || level >= hi_lim) mean_ok = 1'b0;
			all_sum = all_sum + level;
		end
		if (all_sum <= 64'(NCH) * lo_lim || all_sum >= 64'(NCH) * hi_lim) mean_ok = 1'b0;
		if (!(weak_ok && mean_ok)) return VERDICT_NONE;
		return strong_ok ? VERDICT_STRONG : VERDICT_WEAK;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_rec_t got;
		verdict_rec_t want;
		if (!arst_n) begin
			thresholds = '{weak_pm: WEAK_DEFAULT, strong_pm: STRONG_DEFAULT,
				low: LOW_DEFAULT, high: HIGH_DEFAULT};
			clear_sequence();
			verdicts_due.delete();
			error_cnt   = 0;
			checked_cnt = 0;
		end else begin
			// verdict request against the oldest one due
			if (out_valid && out_ready) begin
				got = {noise_verdict, count_overflow};
				if (verdicts_due.size() == 0) begin
					$display("%0t: verdict request with none due: verdict %0d overflow %0d",
						$time, got.verdict, got.overflow);
					error_cnt++;
				end else begin
					want = verdicts_due.pop_front();
					checked_cnt++;
					if (got.verdict !== want.verdict) begin
						$display("%0t: noise_verdict mismatch: expected %0d, actual %0d",
							$time, want.verdict, got.verdict);
						error_cnt++;
					end
					if (got.overflow !== want.overflow) begin
						$display("%0t: count_overflow mismatch: expected %0d, actual %0d",
							$time, want.overflow, got.overflow);
						error_cnt++;
					end
				end
			end

			// register write
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_WEAK:   thresholds.weak_pm   = cfg_data;
					CFG_STRONG: thresholds.strong_pm = cfg_data;
					CFG_LOW:    thresholds.low       = cfg_data[BOUND_W-1:0];
					CFG_HIGH:   thresholds.high      = cfg_data[BOUND_W-1:0];
					default: ;
				endcase
			end

			// pixel request; the closing pixel counts before the verdict
			if (in_valid && in_ready) begin
				fold_pixel({red_value, green_value, blue_value});
				if (sequence_end) begin
					want.verdict  = judge_sequence();
					want.overflow = clipped;
					verdicts_due.push_back(want);
					clear_sequence();
				end
			end
		end
		errors           <= error_cnt;
		pending          <= verdicts_due.size();
		verdicts_checked <= checked_cnt;
	end

endmodule

// File: test/rgb_histogram_noise_classifier_tb.sv
// testbench top for the rgb extreme-bin noise classifier: clock, reset, pixel and
// register stimulus, verdict sink, watchdog and final verdict
// depends on rhnc_pkg, rgb_histogram_noise_classifier and rhnc_verdict_checker
module rgb_histogram_noise_classifier_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rhnc_pkg::*;

	localparam int PIXEL_GOAL    = 1850;
	localparam int GAP_MAX       = 6;
	localparam int SETTLE_CYCLES = 12;
	localparam int QUIET_LIMIT   = 2000;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [SAMPLE_W-1:0]   blue_value;
	logic [SAMPLE_W-1:0]   green_value;
	logic [SAMPLE_W-1:0]   red_value;
	logic                  sequence_end;
	logic                  out_valid;
	logic                  out_ready;
	logic [1:0]            noise_verdict;
	logic                  count_overflow;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [PERMILLE_W-1:0] cfg_data;

	int   errors;
	int   pending;
	int   verdicts_checked;
	int   pixels_sent    = 0;
	int   sequences_sent = 0;
	int   cfg_writes     = 0;
	int   phases         = 0;
	int   quiet_cycles   = 0;
	logic quiet_tx       = 1'b0;
	logic quiet_rx       = 1'b0;

	rgb_histogram_noise_classifier dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.blue_value     (blue_value),
		.green_value    (green_value),
		.red_value      (red_value),
		.sequence_end   (sequence_end),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.noise_verdict  (noise_verdict),
		.count_overflow (count_overflow),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	rhnc_verdict_checker verdict_watch (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.blue_value       (blue_value),
		.green_value      (green_value),
		.red_value        (red_value),
		.sequence_end     (sequence_end),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.noise_verdict    (noise_verdict),
		.count_overflow   (count_overflow),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.errors           (errors),
		.pending          (pending),
		.verdicts_checked (verdicts_checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// verdict sink: random stall before each request, none in quiet phases
	initial begin
		int stall;
		out_ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = quiet_rx ? 0 : $urandom_range(0, GAP_MAX);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// watchdog on cycles in which no request moves on any channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: watchdog: nothing accepted for %0d cycles", $time, QUIET_LIMIT);
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one pixel request, with a random gap before it outside quiet phases
	task automatic send_pixel(input logic [SAMPLE_W-1:0] b, g, r, input logic closing);
		int gap;
		gap = quiet_tx ? 0 : $urandom_range(0, GAP_MAX);
		cfg_valid <= 1'b0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		blue_value   <= b;
		green_value  <= g;
		red_value    <= r;
		sequence_end <= closing;
		do @(posedge clk); while (!in_ready);
		pixels_sent++;
		if (closing) sequences_sent++;
	endtask

	// register write; valid is lowered by the next pixel request
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [PERMILLE_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_writes++;
	endtask

	// stop feeding, wait for every verdict and let the pipeline empty
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// every channel gets one dark and one bright pixel, means just under 128
	task automatic send_extreme_trio();
		send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
		send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
		send_pixel(8'd127, 8'd128, 8'd127, 1'b1);
	endtask

	function automatic logic [PERMILLE_W-1:0] pick_permille(input int span);
		case ($urandom_range(0, 9))
			0:       return 10'd0;
			1:       return 10'd1000;
			2:       return 10'd1023;
			default: return PERMILLE_W'($urandom_range(0, span));
		endcase
	endfunction

	function automatic logic [PERMILLE_W-1:0] pick_bound(input int lo, input int hi);
		case ($urandom_range(0, 9))
			0:       return 10'd0;
			1:       return 10'd255;
			default: return PERMILLE_W'($urandom_range(lo, hi));
		endcase
	endfunction

	// well-formed samples lean on 0, 255 and mid-grey; noisy ones are uniform
	function automatic logic [SAMPLE_W-1:0] draw_sample(input logic noisy);
		int roll;
		roll = $urandom_range(0, 99);
		if (noisy) return SAMPLE_W'($urandom_range(0, 255));
		if (roll < 15) return SAMPLE_MIN;
		if (roll < 30) return SAMPLE_MAX;
		return SAMPLE_W'($urandom_range(100, 160));
	endfunction

	task automatic send_sequence();
		int   len;
		int   k;
		logic noisy;
		len   = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
		noisy = ($urandom_range(0, 4) == 0);
		for (k = 0; k < len; k++)
			send_pixel(draw_sample(noisy), draw_sample(noisy), draw_sample(noisy), k == len - 1);
	endtask

	task automatic reshuffle_thresholds();
		if ($urandom_range(0, 1)) cfg_write(CFG_WEAK, pick_permille(60));
		if ($urandom_range(0, 1)) cfg_write(CFG_STRONG, pick_permille(200));
		if ($urandom_range(0, 1)) cfg_write(CFG_LOW, pick_bound(90, 127));
		if ($urandom_range(0, 1)) cfg_write(CFG_HIGH, pick_bound(129, 170));
	endtask

	initial begin
		int directed_pixels;
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		blue_value   <= '0;
		green_value  <= '0;
		red_value    <= '0;
		sequence_end <= 1'b0;
		cfg_valid    <= 1'b0;
		cfg_index    <= CFG_WEAK;
		cfg_data     <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default thresholds: single-pixel sequences and a strong signature
		send_pixel(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 1'b1);
		send_pixel(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b1);
		send_extreme_trio();
		drain();

		// zero weak threshold, strong out of reach: weak verdict, then no extremes at all
		cfg_write(CFG_WEAK, 10'd0);
		cfg_write(CFG_STRONG, 10'd1000);
		send_extreme_trio();
		send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
		send_pixel(8'd130, 8'd120, 8'd125, 1'b1);
		drain();

		// thresholds above 1000 and the widest mean window
		cfg_write(CFG_WEAK, 10'd1023);
		cfg_write(CFG_STRONG, 10'd1023);
		cfg_write(CFG_LOW, 10'd0);
		cfg_write(CFG_HIGH, 10'd255);
		send_extreme_trio();
		send_pixel(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b1);
		drain();

		// empty mean window with low above high
		cfg_write(CFG_WEAK, 10'd0);
		cfg_write(CFG_STRONG, 10'd0);
		cfg_write(CFG_LOW, 10'd200);
		cfg_write(CFG_HIGH, 10'd100);
		send_extreme_trio();
		drain();

		// narrow window, bound write with upper data bits set
		cfg_write(CFG_LOW, 10'h37E);
		cfg_write(CFG_HIGH, 10'd129);
		send_extreme_trio();
		drain();
		directed_pixels = pixels_sent;

		// random phases: new thresholds, a burst of sequences, then drain
		while (pixels_sent < directed_pixels + PIXEL_GOAL) begin
			quiet_tx = ($urandom_range(0, 3) == 0);
			quiet_rx = ($urandom_range(0, 3) == 0);
			reshuffle_thresholds();
			repeat ($urandom_range(2, 8)) send_sequence();
			drain();
			phases++;
		end

		$display("covered %0d pixels in %0d sequences, %0d verdicts checked",
			pixels_sent, sequences_sent, verdicts_checked);
		$display("%0d register writes over %0d random phases, with and without idle gaps",
			cfg_writes, phases);
		if (errors == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/rhnc_pkg.sv
rtl/rhnc_accum.sv
rtl/rhnc_scale.sv
rtl/rhnc_decide.sv
rtl/rgb_histogram_noise_classifier.sv
test/rhnc_verdict_checker.sv
test/rgb_histogram_noise_classifier_tb.sv
